// ===== design/alarm_clock_menu_controller_assert.svh =====
// Assertion macros for the alarm clock menu controller.
// Relies on i_clk and i_rst_n being visible where the macros are used.
`ifndef ALARM_CLOCK_MENU_CONTROLLER_ASSERT_SVH
`define ALARM_CLOCK_MENU_CONTROLLER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define ACMC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("acmc assertion failed");
`define ACMC_ASSERT_NEXT(lbl, cond, nxt) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (nxt)) \
        else $error("acmc assertion failed");
`else
`define ACMC_ASSERT(lbl, prop)
`define ACMC_ASSERT_NEXT(lbl, cond, nxt)
`endif

`endif

// ===== design/acmc_pkg.sv =====
// Types and constants shared by the alarm clock menu controller.
// No dependencies.
package acmc_pkg;

    typedef logic [3:0] t_mode;

    localparam t_mode M_NORMAL  = 4'd0;
    localparam t_mode M_MENU    = 4'd1;
    localparam t_mode M_YEAR    = 4'd2;
    localparam t_mode M_MONTH   = 4'd3;
    localparam t_mode M_DAY     = 4'd4;
    localparam t_mode M_HOUR    = 4'd5;
    localparam t_mode M_MINUTE  = 4'd6;
    localparam t_mode M_SUCCESS = 4'd7;
    localparam t_mode M_SLOT    = 4'd8;
    localparam t_mode M_ALTER   = 4'd9;
    localparam t_mode M_AHOUR   = 4'd10;
    localparam t_mode M_AMINUTE = 4'd11;

    // register indexes on the configuration port
    localparam logic REG_YEAR_CHOICES = 1'b0;
    localparam logic REG_WRITE_SECOND = 1'b1;

    localparam logic [7:0] ALARM_UNSET = 8'hFF;

    typedef struct packed {
        logic       conf_level;
        logic       minus_level;
        logic       plus_level;
        logic       enter_level;
        logic [4:0] now_hour;
        logic [5:0] now_minute;
        logic [5:0] now_second;
        logic [4:0] now_day;
        logic [3:0] now_month;
        logic [6:0] now_year;
    } t_in;

    typedef struct packed {
        logic [3:0] menu_state;
        logic [6:0] option_value;
        logic [4:0] alarm_slot;
        logic       date_write;
        logic [6:0] write_year;
        logic [6:0] write_month;
        logic [6:0] write_day;
        logic [6:0] write_hour;
        logic [6:0] write_minute;
        logic       edit_done;
        logic       alarm_fire;
    } t_out;

endpackage

// ===== design/acmc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module acmc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 26
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/alarm_clock_menu_controller.sv =====
// Alarm clock menu controller: menu state machine plus alarm table scan.
// Depends on acmc_pkg, acmc_ram and alarm_clock_menu_controller_assert.svh.
//
// Usage:
// - Input channel (i_in_valid / o_in_ready, payload i_in) carries one poll
//   per beat: four button levels and the clock time and date.
// - Output channel (o_out_valid / i_out_ready, payload o_out) carries one
//   result beat per poll, in order.
// - Configuration over the APB-style port: year_choices at 0x0, write_second
//   at 0x4; pready is always high, reads return the stored value.
// - A poll updates the menu in its accept cycle, then the alarm RAM is read
//   one slot per cycle through states S_SCAN and S_FIN. The result is
//   registered in S_OUT, and no new poll is taken until the block is back in
//   S_IDLE, a pace set by the one read port of the RAM.
// - The result sits in an output register; if the receiver stalls, the
//   next poll is still processed and then waits for that register to free.
// - Reset clears the menu state and one valid flop per alarm slot, so every
//   slot reads as unset at once; no clearing pass is needed.
module alarm_clock_menu_controller #(
    parameter int ALARM_SLOTS = 26
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  acmc_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output acmc_pkg::t_out  o_out,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);
    import acmc_pkg::*;

    `include "alarm_clock_menu_controller_assert.svh"

    localparam int ADDR_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(ALARM_SLOTS - 1);
    localparam logic [6:0] SLOT_LIMIT = 7'(ALARM_SLOTS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_FIN  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state;

    // configuration
    logic [6:0] r_year_choices;
    logic [5:0] r_write_second;

    // menu state
    t_mode      r_mode;
    logic [6:0] r_option, r_limit;
    logic [4:0] r_slot;
    logic [3:0] r_btn;
    logic [6:0] r_sy, r_sm, r_sd, r_sh;
    logic [7:0] r_sah;
    logic [ALARM_SLOTS-1:0] r_valid;

    // per-poll working registers
    logic [4:0] r_hr;
    logic [5:0] r_mn;
    logic       r_sec_one;
    logic       r_dw, r_done, r_fire;
    logic [6:0] r_wmin;

    // scan control
    logic [ADDR_W-1:0] r_cnt, r_chk_idx;
    logic              r_chk;

    logic r_out_vld;
    t_out r_out;

    // next values of the menu step
    t_mode      n_mode;
    logic [6:0] n_option, n_limit, n_sy, n_sm, n_sd, n_sh, n_wmin;
    logic [4:0] n_slot;
    logic [7:0] n_sah;
    logic [7:0] n_amin;
    logic       n_dw, n_done;
    logic       n_del, n_commit;

    logic       in_accept, out_accept, cfg_write;
    logic [3:0] lv, rise;
    logic       slot_ok;
    logic [ADDR_W-1:0] slot_addr;
    logic [6:0] slot_m1;
    logic [15:0] ram_rdata;
    logic       ram_we;
    logic       hit;

    assign in_accept  = i_in_valid && o_in_ready;
    assign out_accept = r_out_vld && i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out = r_out;
    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[2])
            REG_YEAR_CHOICES: prdata = {25'd0, r_year_choices};
            REG_WRITE_SECOND: prdata = {26'd0, r_write_second};
            default:          prdata = 32'd0;
        endcase
    end

    assign lv = {i_in.enter_level, i_in.plus_level, i_in.minus_level, i_in.conf_level};
    assign rise = lv & ~r_btn;
    assign slot_ok = (r_slot != 5'd0) && ({2'b00, r_slot} <= SLOT_LIMIT);
    assign slot_m1 = {2'b00, r_slot} - 7'd1;
    assign slot_addr = slot_m1[ADDR_W-1:0];

    always_comb begin
        logic [7:0] opt_p1;
        opt_p1   = 8'd0;
        n_mode   = r_mode;
        n_option = r_option;
        n_limit  = r_limit;
        n_slot   = r_slot;
        n_sy     = r_sy;
        n_sm     = r_sm;
        n_sd     = r_sd;
        n_sh     = r_sh;
        n_sah    = r_sah;
        n_amin   = 8'd0;
        n_wmin   = 7'd0;
        n_dw     = 1'b0;
        n_done   = 1'b0;
        n_del    = 1'b0;
        n_commit = 1'b0;

        if (rise[0]) begin
            if (n_mode == M_NORMAL) begin
                n_mode = M_MENU;
            end else begin
                n_mode   = M_NORMAL;
                n_option = 7'd1;
            end
        end
        if (rise[1]) begin
            n_option = (n_option <= 7'd1) ? r_limit : n_option - 7'd1;
        end
        if (rise[2]) begin
            opt_p1 = {1'b0, n_option} + 8'd1;
            n_option = (opt_p1 > {1'b0, r_limit}) ? 7'd1 : opt_p1[6:0];
        end
        if (rise[3]) begin
            case (n_mode)
                M_MENU: begin
                    if (n_option == 7'd1) begin
                        n_mode   = M_YEAR;
                        n_option = i_in.now_year;
                    end else if (n_option == 7'd2) begin
                        n_mode   = M_SLOT;
                        n_option = 7'd1;
                    end
                end
                M_YEAR: begin
                    n_sy     = n_option;
                    n_mode   = M_MONTH;
                    n_option = {3'b000, i_in.now_month};
                end
                M_MONTH: begin
                    n_sm     = n_option;
                    n_mode   = M_DAY;
                    n_option = {2'b00, i_in.now_day};
                end
                M_DAY: begin
                    n_sd     = n_option;
                    n_mode   = M_HOUR;
                    n_option = {2'b00, i_in.now_hour} + 7'd1;
                end
                M_HOUR: begin
                    n_sh     = n_option - 7'd1;
                    n_mode   = M_MINUTE;
                    n_option = {1'b0, i_in.now_minute} + 7'd1;
                end
                M_MINUTE: begin
                    n_wmin = n_option - 7'd1;
                    n_dw   = 1'b1;
                    n_mode = M_SUCCESS;
                end
                M_SLOT: begin
                    n_slot   = n_option[4:0];
                    n_mode   = M_ALTER;
                    n_option = 7'd1;
                end
                M_ALTER: begin
                    if (n_option == 7'd1) begin
                        n_mode   = M_AHOUR;
                        n_option = 7'd1;
                    end else if (n_option == 7'd2) begin
                        n_del  = slot_ok;
                        n_mode = M_SUCCESS;
                    end
                end
                M_AHOUR: begin
                    n_sah    = {1'b0, n_option} - 8'd1;
                    n_mode   = M_AMINUTE;
                    n_option = 7'd1;
                end
                M_AMINUTE: begin
                    // the alarm minute is committed with the staged hour
                    n_amin   = {1'b0, n_option} - 8'd1;
                    n_commit = slot_ok;
                    n_mode   = M_SUCCESS;
                end
                default: begin
                end
            endcase
        end

        case (n_mode)
            M_MENU, M_ALTER:    n_limit = 7'd2;
            M_YEAR:             n_limit = r_year_choices;
            M_MONTH:            n_limit = 7'd12;
            M_DAY:              n_limit = 7'd31;
            M_HOUR, M_AHOUR:    n_limit = 7'd24;
            M_MINUTE, M_AMINUTE: n_limit = 7'd60;
            M_SLOT:             n_limit = SLOT_LIMIT;
            M_SUCCESS: begin
                n_mode   = M_NORMAL;
                n_option = 7'd1;
                n_done   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign ram_we = in_accept && n_commit;

    acmc_ram #(
        .WIDTH(16),
        .DEPTH(ALARM_SLOTS)
    ) u_alarm_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(slot_addr),
        .i_wdata({r_sah, n_amin}),
        .i_raddr(r_cnt),
        .o_rdata(ram_rdata)
    );

    // an unset entry is masked by its valid flop, not by its RAM contents
    assign hit = r_chk && r_valid[r_chk_idx] && r_sec_one
              && (ram_rdata[15:8] == {3'b000, r_hr})
              && (ram_rdata[7:0] == {2'b00, r_mn});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_year_choices <= 7'd50;
            r_write_second <= 6'd17;
            r_mode         <= M_NORMAL;
            r_option       <= 7'd1;
            r_limit        <= 7'd2;
            r_slot         <= 5'd1;
            r_btn          <= 4'd0;
            r_sy           <= 7'd17;
            r_sm           <= 7'd7;
            r_sd           <= 7'd17;
            r_sh           <= 7'd17;
            r_sah          <= ALARM_UNSET;
            r_valid        <= '0;
            r_cnt          <= '0;
            r_chk          <= 1'b0;
            r_fire         <= 1'b0;
            r_out_vld      <= 1'b0;
        end else begin
            if (cfg_write) begin
                unique case (paddr[2])
                    REG_YEAR_CHOICES: r_year_choices <= pwdata[6:0];
                    REG_WRITE_SECOND: r_write_second <= pwdata[5:0];
                    default: begin
                    end
                endcase
            end

            if (r_state == S_OUT && (!r_out_vld || i_out_ready)) begin
                r_out_vld <= 1'b1;
            end else if (out_accept) begin
                r_out_vld <= 1'b0;
            end

            r_chk <= (r_state == S_SCAN);
            if (hit) begin
                r_fire <= 1'b1;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_btn    <= lv;
                        r_mode   <= n_mode;
                        r_option <= n_option;
                        r_limit  <= n_limit;
                        r_slot   <= n_slot;
                        r_sy     <= n_sy;
                        r_sm     <= n_sm;
                        r_sd     <= n_sd;
                        r_sh     <= n_sh;
                        r_sah    <= n_sah;
                        if (n_commit) begin
                            r_valid[slot_addr] <= 1'b1;
                        end
                        if (n_del) begin
                            r_valid[slot_addr] <= 1'b0;
                        end
                        r_fire  <= 1'b0;
                        r_cnt   <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_cnt == LAST_SLOT) begin
                        r_state <= S_FIN;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_FIN: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // hold until the output register frees up
                    if (!r_out_vld || i_out_ready) begin
                        if (r_fire) begin
                            r_mode <= M_NORMAL;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // per-poll payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_hr      <= i_in.now_hour;
            r_mn      <= i_in.now_minute;
            r_sec_one <= (i_in.now_second == 6'd1);
            r_dw      <= n_dw;
            r_done    <= n_done;
            r_wmin    <= n_wmin;
        end
        r_chk_idx <= r_cnt;
        if (r_state == S_OUT && (!r_out_vld || i_out_ready)) begin
            r_out.menu_state   <= r_fire ? M_NORMAL : r_mode;
            r_out.option_value <= r_option;
            r_out.alarm_slot   <= r_slot;
            r_out.date_write   <= r_dw;
            r_out.write_year   <= r_dw ? r_sy : 7'd0;
            r_out.write_month  <= r_dw ? r_sm : 7'd0;
            r_out.write_day    <= r_dw ? r_sd : 7'd0;
            r_out.write_hour   <= r_dw ? r_sh : 7'd0;
            r_out.write_minute <= r_dw ? r_wmin : 7'd0;
            r_out.edit_done    <= r_done;
            r_out.alarm_fire   <= r_fire;
        end
    end

    `ACMC_ASSERT_NEXT(a_accept_starts_scan, in_accept, r_state == S_SCAN)
    `ACMC_ASSERT(a_fire_normal, !(o_out_valid && o_out.alarm_fire) || o_out.menu_state == M_NORMAL)
    `ACMC_ASSERT(a_write_done, !(o_out_valid && o_out.date_write) || o_out.edit_done)
    `ACMC_ASSERT(a_ram_write_on_accept, !ram_we || in_accept)

endmodule
